// ----- hw/rtl/lut3d_pkg.sv -----
// ============================================================================
// lut3d_pkg
// Shared widths, fixed-point constants and request codes for the 3D LUT grader.
// ============================================================================
package lut3d_pkg;

    localparam int FRAC_W     = 16;   // Q.16 fraction bits
    localparam int PIX_W      = 24;   // Q8.16 pixel channel
    localparam int ENT_PORT_W = 16;   // table entry port width
    localparam int IDX_PORT_W = 5;    // grid coordinate port width
    localparam int CFG_W      = 5;    // grid_size register width

    localparam logic [PIX_W-1:0] ONE_Q16  = 24'h010000;
    localparam logic [PIX_W-1:0] EPS_Q16  = 24'd66;     // 0.001 in Q.16
    localparam logic [PIX_W-1:0] OUT_MAX  = 24'hFFFFFF;
    localparam logic [CFG_W-1:0] GRID_RST = 5'd17;
    localparam logic [FRAC_W:0]  HALF_LSB = 17'h08000;  // rounding term

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

endpackage

// ----- hw/rtl/lut3d_trilinear_color_grade.sv -----
// ============================================================================
// lut3d_trilinear_color_grade
// 3D LUT colour grader with trilinear interpolation and HDR range scaling.
// ============================================================================
//
//  Channel | Handshake            | Payload
//  --------+----------------------+--------------------------------------------
//  cfg     | cfg_we               | cfg_wdata (grid_size)
//  in      | in_valid / in_ready  | action, index_*, entry_*, pixel_*
//  out     | out_valid / out_ready| out_red, out_green, out_blue
//
//  One request per clock while no result is held. The pipeline depth is set
//  by the bit-per-stage position divider.
//  Reset clears the pipeline valids and sets grid_size to 17; the table is
//  not cleared and holds rubbish until written.
//  A held result stalls every stage together; nothing is dropped or doubled.
//
//  Pipeline: input register, max/scale/multiply, divider, grid index and
//  fraction, banked table read, blue/green/red blend, Q8.16 conversion,
//  HDR rescale with saturation into the output register.
//  Load requests run down the same pipe and write the table at the read
//  stage, so table order with respect to pixels is kept.
// ============================================================================
module lut3d_trilinear_color_grade #(
    parameter int MAX_GRID   = 17,
    parameter int ENTRY_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lut3d_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [lut3d_pkg::IDX_PORT_W-1:0]  index_red,
    input  logic [lut3d_pkg::IDX_PORT_W-1:0]  index_green,
    input  logic [lut3d_pkg::IDX_PORT_W-1:0]  index_blue,
    input  logic [lut3d_pkg::ENT_PORT_W-1:0]  entry_red,
    input  logic [lut3d_pkg::ENT_PORT_W-1:0]  entry_green,
    input  logic [lut3d_pkg::ENT_PORT_W-1:0]  entry_blue,
    input  logic [lut3d_pkg::PIX_W-1:0]       pixel_red,
    input  logic [lut3d_pkg::PIX_W-1:0]       pixel_green,
    input  logic [lut3d_pkg::PIX_W-1:0]       pixel_blue,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lut3d_pkg::PIX_W-1:0]       out_red,
    output logic [lut3d_pkg::PIX_W-1:0]       out_green,
    output logic [lut3d_pkg::PIX_W-1:0]       out_blue
);
    import lut3d_pkg::*;

    localparam int GW  = $clog2(MAX_GRID);          // holds grid_size - 1
    localparam int CW  = $clog2(MAX_GRID + 1);      // holds low index + 1
    localparam int QB  = FRAC_W + GW;               // grid position bits
    localparam int DW  = PIX_W + 1;                 // max channel + eps
    localparam int PGW = PIX_W + GW;
    localparam int EW  = (ENTRY_BITS < ENT_PORT_W) ? ENTRY_BITS : ENT_PORT_W;
    localparam int H   = MAX_GRID / 2 + 1;          // bank extent per axis
    localparam int BD  = H * H * H;
    localparam int AW  = $clog2(BD);
    localparam int NW  = ENTRY_BITS + FRAC_W + 1;
    localparam int XW  = FRAC_W + 1;
    localparam int PW  = DW + XW;
    localparam int SBW = 1 + 3 * IDX_PORT_W + 3 * EW + 1 + 3 * QB;
    localparam logic [NW-1:0] FS = NW'((64'd1 << ENTRY_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [AW-1:0] cell_addr(input int hr, input int hg, input int hb);
        return AW'((hr * H + hg) * H + hb);
    endfunction

    // round(v * 2^16 / fs) with fs = 2^ENTRY_BITS - 1, by folding the high part
    function automatic logic [XW-1:0] to_q16(input logic [EW-1:0] v);
        logic [NW-1:0] t;
        logic [NW-1:0] q;
        logic [NW-1:0] hq;
        t = (NW'(v) << FRAC_W) + (FS >> 1);
        q = '0;
        for (int i = 0; i < 4; i++)
        begin
            hq = t >> ENTRY_BITS;
            q  = q + hq;
            t  = hq + (t & FS);
        end
        for (int i = 0; i < 2; i++)
        begin
            if (t >= FS)
            begin
                q = q + NW'(1);
                t = t - FS;
            end
        end
        return XW'(q);
    endfunction

    // ------------------------------------------------------------------
    // flow control: whole pipe moves unless a result is held
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    logic accept;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // ------------------------------------------------------------------
    // grid_size register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] grid_reg;
    logic [GW-1:0]    gm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grid_reg <= GRID_RST;
        else if (cfg_we)
            grid_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (grid_reg < CFG_W'(2))
            gm1 = GW'(1);
        else if (32'(grid_reg) > MAX_GRID)
            gm1 = GW'(MAX_GRID - 1);
        else
            gm1 = GW'(grid_reg - CFG_W'(1));
    end

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_action_reg;
    logic [IDX_PORT_W-1:0] s1_idx_reg [3];
    logic [EW-1:0]         s1_ent_reg [3];
    logic [PIX_W-1:0]      s1_pix_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= action;
            s1_idx_reg[0] <= index_red;
            s1_idx_reg[1] <= index_green;
            s1_idx_reg[2] <= index_blue;
            s1_ent_reg[0] <= entry_red[EW-1:0];
            s1_ent_reg[1] <= entry_green[EW-1:0];
            s1_ent_reg[2] <= entry_blue[EW-1:0];
            s1_pix_reg[0] <= pixel_red;
            s1_pix_reg[1] <= pixel_green;
            s1_pix_reg[2] <= pixel_blue;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: max channel, HDR flag, divisor, c * (G-1)
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] maxc;
    logic             emis;

    always_comb
    begin
        maxc = s1_pix_reg[0];
        if (s1_pix_reg[1] > maxc)
            maxc = s1_pix_reg[1];
        if (s1_pix_reg[2] > maxc)
            maxc = s1_pix_reg[2];
        emis = (s1_pix_reg[0] > ONE_Q16) || (s1_pix_reg[1] > ONE_Q16) ||
               (s1_pix_reg[2] > ONE_Q16);
    end

    logic                  s2_valid_reg;
    logic                  s2_action_reg;
    logic [IDX_PORT_W-1:0] s2_idx_reg [3];
    logic [EW-1:0]         s2_ent_reg [3];
    logic                  s2_emis_reg;
    logic [DW-1:0]         s2_d_reg;
    logic [PGW-1:0]        s2_prod_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_action_reg <= s1_action_reg;
            s2_idx_reg    <= s1_idx_reg;
            s2_ent_reg    <= s1_ent_reg;
            s2_emis_reg   <= emis;
            s2_d_reg      <= emis ? (DW'(maxc) + DW'(EPS_Q16)) : '0;
            for (int k = 0; k < 3; k++)
                s2_prod_reg[k] <= PGW'(s1_pix_reg[k]) * PGW'(gm1);
        end
    end

    // ------------------------------------------------------------------
    // divider: position = (c * (G-1) << 16) / d for HDR pixels
    // ------------------------------------------------------------------
    logic [DW-1:0]         rem0 [3];
    logic [QB-1:0]         num0 [3];
    logic [QB-1:0]         pnon [3];
    logic [SBW-1:0]        div_sb_in;
    logic [SBW-1:0]        div_sb_out;
    logic                  dv_valid;
    logic [QB-1:0]         dv_quo [3];
    logic [DW-1:0]         dv_d;
    logic                  dv_action;
    logic [IDX_PORT_W-1:0] dv_idx [3];
    logic [EW-1:0]         dv_ent [3];
    logic                  dv_emis;
    logic [QB-1:0]         dv_pnon [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rem0[k] = DW'(s2_prod_reg[k] >> GW);
            num0[k] = {s2_prod_reg[k][GW-1:0], {FRAC_W{1'b0}}};
            pnon[k] = s2_prod_reg[k][QB-1:0];
        end
    end

    assign div_sb_in = {s2_action_reg, s2_idx_reg[0], s2_idx_reg[1], s2_idx_reg[2],
                        s2_ent_reg[0], s2_ent_reg[1], s2_ent_reg[2], s2_emis_reg,
                        pnon[0], pnon[1], pnon[2]};

    assign {dv_action, dv_idx[0], dv_idx[1], dv_idx[2], dv_ent[0], dv_ent[1], dv_ent[2],
            dv_emis, dv_pnon[0], dv_pnon[1], dv_pnon[2]} = div_sb_out;

    lut3d_div_pipe #(
        .DW  (DW),
        .QB  (QB),
        .SBW (SBW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s2_valid_reg),
        .divisor     (s2_d_reg),
        .rem_in      (rem0),
        .num_in      (num0),
        .sb_in       (div_sb_in),
        .out_valid   (dv_valid),
        .quo         (dv_quo),
        .divisor_out (dv_d),
        .sb_out      (div_sb_out)
    );

    // ------------------------------------------------------------------
    // stage L: low grid index and fraction, clamped at the top point
    // ------------------------------------------------------------------
    logic [GW-1:0]     lo_next [3];
    logic [FRAC_W-1:0] fr_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [QB-1:0] p;
            p = dv_emis ? dv_quo[k] : dv_pnon[k];
            lo_next[k] = p[QB-1:FRAC_W];
            fr_next[k] = p[FRAC_W-1:0];
            if (lo_next[k] >= gm1)
            begin
                lo_next[k] = gm1;
                fr_next[k] = '0;
            end
        end
    end

    logic                  sl_valid_reg;
    logic                  sl_action_reg;
    logic [IDX_PORT_W-1:0] sl_idx_reg [3];
    logic [EW-1:0]         sl_ent_reg [3];
    logic                  sl_emis_reg;
    logic [DW-1:0]         sl_d_reg;
    logic [GW-1:0]         sl_lo_reg [3];
    logic [FRAC_W-1:0]     sl_fr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sl_valid_reg <= 1'b0;
        else if (adv)
            sl_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_action_reg <= dv_action;
            sl_idx_reg    <= dv_idx;
            sl_ent_reg    <= dv_ent;
            sl_emis_reg   <= dv_emis;
            sl_d_reg      <= dv_d;
            sl_lo_reg     <= lo_next;
            sl_fr_reg     <= fr_next;
        end
    end

    // ------------------------------------------------------------------
    // bank addressing: for each axis pick lo or lo+1 by parity; when the
    // fraction is zero the lo+1 read is discarded after the banks
    // ------------------------------------------------------------------
    logic [CW-1:0]     half [3][2];
    logic [AW-1:0]     rd_addr [8];
    logic [3*EW-1:0]   rd_data [8];
    logic              lut_we;
    logic [2:0]        wr_bank;
    logic [AW-1:0]     wr_addr;
    logic              wr_in_range;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                logic [CW-1:0] coord;
                if (sl_lo_reg[k][0] == 1'(b))
                    coord = CW'(sl_lo_reg[k]);
                else
                    coord = CW'(sl_lo_reg[k]) + CW'(1);
                half[k][b] = coord >> 1;
            end
        end
        for (int n = 0; n < 8; n++)
        begin
            logic [2:0] nb;
            nb = 3'(n);
            rd_addr[n] = cell_addr(int'(half[0][nb[2]]), int'(half[1][nb[1]]),
                                   int'(half[2][nb[0]]));
        end
    end

    assign wr_in_range = (int'(sl_idx_reg[0]) < MAX_GRID) &&
                         (int'(sl_idx_reg[1]) < MAX_GRID) &&
                         (int'(sl_idx_reg[2]) < MAX_GRID);
    assign lut_we  = adv && sl_valid_reg && (sl_action_reg == ACT_LOAD) && wr_in_range;
    assign wr_bank = {sl_idx_reg[0][0], sl_idx_reg[1][0], sl_idx_reg[2][0]};
    assign wr_addr = cell_addr(int'(sl_idx_reg[0] >> 1), int'(sl_idx_reg[1] >> 1),
                               int'(sl_idx_reg[2] >> 1));

    lut3d_lut_banks #(
        .DEPTH  (BD),
        .AW     (AW),
        .DATA_W (3 * EW)
    ) u_banks (
        .clk     (clk),
        .adv     (adv),
        .we      (lut_we),
        .wr_bank (wr_bank),
        .wr_addr (wr_addr),
        .wr_data ({sl_ent_reg[2], sl_ent_reg[1], sl_ent_reg[0]}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // stage M: sideband alongside the bank read
    // ------------------------------------------------------------------
    logic              sm_valid_reg;
    logic              sm_emis_reg;
    logic [DW-1:0]     sm_d_reg;
    logic [2:0]        sm_lob_reg;
    logic [FRAC_W-1:0] sm_fr_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_valid_reg <= 1'b0;
        else if (adv)
            sm_valid_reg <= sl_valid_reg && (sl_action_reg == ACT_PIXEL);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sm_emis_reg <= sl_emis_reg;
            sm_d_reg    <= sl_d_reg;
            sm_lob_reg  <= {sl_lo_reg[0][0], sl_lo_reg[1][0], sl_lo_reg[2][0]};
            sm_fr_reg   <= sl_fr_reg;
        end
    end

    // corner i: bit 2 red, bit 1 green, bit 0 blue; a zero fraction folds the
    // high corner onto the low one
    logic [EW-1:0] corner [3][8];
    logic [2:0]    nz;

    assign nz = {sm_fr_reg[0] != '0, sm_fr_reg[1] != '0, sm_fr_reg[2] != '0};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            logic [2:0] ib;
            logic [2:0] nb;
            ib = 3'(i);
            nb = sm_lob_reg ^ (ib & nz);
            for (int k = 0; k < 3; k++)
                corner[k][i] = rd_data[nb][k*EW +: EW];
        end
    end

    // ------------------------------------------------------------------
    // blend lanes, three stages
    // ------------------------------------------------------------------
    logic [EW-1:0] lane_v [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        lut3d_lerp_lane #(
            .EW (EW)
        ) u_lane (
            .clk      (clk),
            .adv      (adv),
            .corner   (corner[k]),
            .fr_blue  (sm_fr_reg[2]),
            .fr_green (sm_fr_reg[1]),
            .fr_red   (sm_fr_reg[0]),
            .value    (lane_v[k])
        );
    end

    logic          ln_valid_reg [3];
    logic          ln_emis_reg  [3];
    logic [DW-1:0] ln_d_reg     [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
                ln_valid_reg[j] <= 1'b0;
        end
        else if (adv)
        begin
            ln_valid_reg[0] <= sm_valid_reg;
            ln_valid_reg[1] <= ln_valid_reg[0];
            ln_valid_reg[2] <= ln_valid_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_emis_reg[0] <= sm_emis_reg;
            ln_emis_reg[1] <= ln_emis_reg[0];
            ln_emis_reg[2] <= ln_emis_reg[1];
            ln_d_reg[0]    <= sm_d_reg;
            ln_d_reg[1]    <= ln_d_reg[0];
            ln_d_reg[2]    <= ln_d_reg[1];
        end
    end

    // ------------------------------------------------------------------
    // stage C: entry units to Q8.16
    // ------------------------------------------------------------------
    logic          sc_valid_reg;
    logic          sc_emis_reg;
    logic [DW-1:0] sc_d_reg;
    logic [XW-1:0] sc_x_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (adv)
            sc_valid_reg <= ln_valid_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_emis_reg <= ln_emis_reg[2];
            sc_d_reg    <= ln_d_reg[2];
            for (int k = 0; k < 3; k++)
                sc_x_reg[k] <= to_q16(lane_v[k]);
        end
    end

    // ------------------------------------------------------------------
    // output: HDR rescale, saturate, result register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] y_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [PW-1:0] prod;
            logic [PW-FRAC_W-1:0] sc;
            prod = PW'(sc_x_reg[k]) * PW'(sc_d_reg) + PW'(HALF_LSB);
            sc   = prod[PW-1:FRAC_W];
            if (!sc_emis_reg)
                y_next[k] = PIX_W'(sc_x_reg[k]);
            else if (sc > (PW-FRAC_W)'(OUT_MAX))
                y_next[k] = OUT_MAX;
            else
                y_next[k] = sc[PIX_W-1:0];
        end
    end

    logic [PIX_W-1:0] out_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= y_next;
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];

endmodule

// ----- hw/rtl/lut3d_div_pipe.sv -----
// ============================================================================
// lut3d_div_pipe
// Restoring divider, one quotient bit per stage, three channels sharing one
// divisor. Sideband bits ride along with each request.
// ============================================================================
module lut3d_div_pipe #(
    parameter int DW  = 25,
    parameter int QB  = 21,
    parameter int SBW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [DW-1:0] divisor,
    input  logic [DW-1:0] rem_in [3],
    input  logic [QB-1:0] num_in [3],
    input  logic [SBW-1:0] sb_in,
    output logic          out_valid,
    output logic [QB-1:0] quo [3],
    output logic [DW-1:0] divisor_out,
    output logic [SBW-1:0] sb_out
);

    logic          valid_reg [QB];
    logic [DW-1:0] rem_reg   [QB][3];
    logic [QB-1:0] num_reg   [QB][3];
    logic [DW-1:0] d_reg     [QB];
    logic [SBW-1:0] sb_reg   [QB];

    for (genvar g = 0; g < QB; g++)
    begin : g_stage
        logic          v_src;
        logic [DW-1:0] rem_src [3];
        logic [QB-1:0] num_src [3];
        logic [DW-1:0] d_src;
        logic [SBW-1:0] sb_src;
        logic [DW-1:0] rem_step [3];
        logic [QB-1:0] num_step [3];

        if (g == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign rem_src = rem_in;
            assign num_src = num_in;
            assign d_src   = divisor;
            assign sb_src  = sb_in;
        end
        else
        begin : g_rest
            assign v_src   = valid_reg[g-1];
            assign rem_src = rem_reg[g-1];
            assign num_src = num_reg[g-1];
            assign d_src   = d_reg[g-1];
            assign sb_src  = sb_reg[g-1];
        end

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [DW:0] t;
                t = {rem_src[k], num_src[k][QB-1]};
                if (t >= {1'b0, d_src})
                begin
                    rem_step[k] = DW'(t - {1'b0, d_src});
                    num_step[k] = {num_src[k][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_step[k] = t[DW-1:0];
                    num_step[k] = {num_src[k][QB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (adv)
                valid_reg[g] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= rem_step;
                num_reg[g] <= num_step;
                d_reg[g]   <= d_src;
                sb_reg[g]  <= sb_src;
            end
        end
    end

    // after the last step the shift register holds the quotient
    assign out_valid   = valid_reg[QB-1];
    assign quo         = num_reg[QB-1];
    assign divisor_out = d_reg[QB-1];
    assign sb_out      = sb_reg[QB-1];

endmodule

// ----- hw/rtl/lut3d_lut_banks.sv -----
// ============================================================================
// lut3d_lut_banks
// Table store split in eight banks by coordinate parity, so the eight cube
// corners of any cell sit in different banks. Registered reads.
// ============================================================================
module lut3d_lut_banks #(
    parameter int DEPTH  = 729,
    parameter int AW     = 10,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              adv,
    input  logic              we,
    input  logic [2:0]        wr_bank,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr [8],
    output logic [DATA_W-1:0] rd_data [8]
);

    logic [DATA_W-1:0] rd_data_reg [8];

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        logic [DATA_W-1:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (we && (wr_bank == 3'(b)))
                mem[wr_addr] <= wr_data;
            if (adv)
                rd_data_reg[b] <= mem[rd_addr[b]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/lut3d_lerp_lane.sv -----
// ============================================================================
// lut3d_lerp_lane
// Trilinear blend of one colour channel: blue, green, red, one stage each.
// ============================================================================
module lut3d_lerp_lane #(
    parameter int EW = 16
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [EW-1:0]               corner [8],
    input  logic [lut3d_pkg::FRAC_W-1:0] fr_blue,
    input  logic [lut3d_pkg::FRAC_W-1:0] fr_green,
    input  logic [lut3d_pkg::FRAC_W-1:0] fr_red,
    output logic [EW-1:0]               value
);
    import lut3d_pkg::*;

    localparam int SW = EW + FRAC_W + 1;

    function automatic logic [EW-1:0] lerp(input logic [EW-1:0] a,
                                           input logic [EW-1:0] b,
                                           input logic [FRAC_W-1:0] f);
        logic [SW-1:0] s;
        s = SW'(a) * ((SW'(1) << FRAC_W) - SW'(f)) + SW'(b) * SW'(f) + SW'(HALF_LSB);
        return s[FRAC_W +: EW];
    endfunction

    logic [EW-1:0]     l_reg [4];
    logic [FRAC_W-1:0] fg1_reg;
    logic [FRAC_W-1:0] fr1_reg;
    logic [EW-1:0]     m_reg [2];
    logic [FRAC_W-1:0] fr2_reg;
    logic [EW-1:0]     v_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
                l_reg[j] <= lerp(corner[2*j], corner[2*j+1], fr_blue);
            fg1_reg  <= fr_green;
            fr1_reg  <= fr_red;
            m_reg[0] <= lerp(l_reg[0], l_reg[1], fg1_reg);
            m_reg[1] <= lerp(l_reg[2], l_reg[3], fg1_reg);
            fr2_reg  <= fr1_reg;
            v_reg    <= lerp(m_reg[0], m_reg[1], fr2_reg);
        end
    end

    assign value = v_reg;

endmodule
